[rtl/core/pae_pkg.sv]
`timescale 1ns / 1ps

package pae_pkg;

    localparam int NUM_IDS    = 32;
    localparam int ID_BITS    = $clog2(NUM_IDS);
    localparam int OWNER_BITS = 16;
    localparam int TAG_BITS   = 16;
    localparam int RAND_BITS  = 32;

    localparam logic [RAND_BITS-1:0] RAND_STEP = 32'd5659;
    localparam logic [RAND_BITS-1:0] RAND_ADD  = 32'd6277;
    localparam int RAND_SHL_A = 7;
    localparam int RAND_SHR   = 17;
    localparam int RAND_SHL_B = 11;

    typedef logic [ID_BITS-1:0]    t_id;
    typedef logic [OWNER_BITS-1:0] t_owner;
    typedef logic [TAG_BITS-1:0]   t_tag;

    typedef enum logic [1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_RELEASE   = 2'd1,
        CMD_SET_OWNER = 2'd2
    } t_cmd;

    typedef struct packed {
        t_id  id;
        logic evict;
        logic wr_en;
        logic wr_zero;
    } t_decision;

endpackage

[rtl/core/pid_allocator_random_evict_unit.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_command, i_owner_tag, i_target_id
// output    out        o_out_valid / i_out_ready   o_granted_id, o_evicted, o_evicted_owner
//
// Each item passes the accept step, which picks the identifier and issues the owner
// memory read, and then the write-back state, which writes the owner entry back and loads the result.
// The owner memory read is registered; a new item is accepted only from the idle state.
// Reset clears the in-use mask, the random word and all control state; the owner
// memory is not cleared. A full output register holds the item in write-back and
// keeps the input channel stalled until the result is taken.

module pid_allocator_random_evict_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_command,
    input  logic [15:0]            i_owner_tag,
    input  logic [4:0]             i_target_id,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [4:0]             o_granted_id,
    output logic                   o_evicted,
    output logic [15:0]            o_evicted_owner
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_WRITE = 2'b10
    } t_state;

    t_state             r_state;
    t_state             n_state;
    pae_pkg::t_decision dec;
    pae_pkg::t_decision r_dec;
    pae_pkg::t_tag      r_tag;
    pae_pkg::t_owner    rd_owner;
    pae_pkg::t_owner    wr_owner;
    logic               accept;
    logic               advance;
    logic               r_out_valid;
    pae_pkg::t_id       r_out_id;
    logic               r_out_evicted;
    pae_pkg::t_tag      r_out_owner;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign advance    = (r_state == S_WRITE) && (!r_out_valid || i_out_ready);
    assign wr_owner   = r_dec.wr_zero ? '0 : pae_pkg::OWNER_BITS'(r_tag);

    pae_alloc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_command   (pae_pkg::t_cmd'(i_command)),
        .i_target_id (i_target_id),
        .o_dec       (dec)
    );

    pae_owner_ram #(
        .WIDTH (pae_pkg::OWNER_BITS),
        .DEPTH (pae_pkg::NUM_IDS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (advance && r_dec.wr_en),
        .i_waddr (r_dec.id),
        .i_wdata (wr_owner),
        .i_re    (accept),
        .i_raddr (dec.id),
        .o_rdata (rd_owner)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (advance) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dec <= dec;
            r_tag <= i_owner_tag;
        end
        if (advance) begin
            r_out_id      <= r_dec.id;
            r_out_evicted <= r_dec.evict;
            r_out_owner   <= r_dec.evict ? pae_pkg::TAG_BITS'(rd_owner) : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_id    = r_out_id;
    assign o_evicted       = r_out_evicted;
    assign o_evicted_owner = r_out_owner;

    a_accept_to_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_WRITE)
        else $error("accepted item did not enter write-back");

    a_result_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_WRITE))
        else $error("result appeared without a write-back step");

    a_owner_only_on_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted |-> o_evicted_owner == '0)
        else $error("previous owner reported without an eviction");

endmodule

[rtl/core/pae_owner_ram.sv]
`timescale 1ns / 1ps

module pae_owner_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/pae_alloc_core.sv]
`timescale 1ns / 1ps

module pae_alloc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pae_pkg::t_cmd      i_command,
    input  pae_pkg::t_id       i_target_id,
    output pae_pkg::t_decision o_dec
);

    logic [pae_pkg::NUM_IDS-1:0]   r_mask;
    logic [pae_pkg::NUM_IDS-1:0]   n_mask;
    logic [pae_pkg::RAND_BITS-1:0] r_rand;
    logic [pae_pkg::RAND_BITS-1:0] n_rand;

    logic [pae_pkg::NUM_IDS-1:0]   free_bits;
    logic                          any_free;
    pae_pkg::t_id                  hi_free;
    logic [pae_pkg::RAND_BITS-1:0] rand_step;
    logic [pae_pkg::RAND_BITS-1:0] rand_mix;
    logic [pae_pkg::RAND_BITS-1:0] rand_scr;

    assign free_bits = ~r_mask;
    assign any_free  = |free_bits;
    assign rand_step = r_rand + pae_pkg::RAND_STEP;
    assign rand_mix  = rand_step + (rand_step << pae_pkg::RAND_SHL_A) + pae_pkg::RAND_ADD;
    assign rand_scr  = (rand_mix << pae_pkg::RAND_SHL_A) ^ (rand_mix >> pae_pkg::RAND_SHR)
                     ^ (rand_mix << pae_pkg::RAND_SHL_B);

    always_comb begin
        hi_free = '0;
        for (int i = 0; i < pae_pkg::NUM_IDS; i++) begin
            if (free_bits[i]) begin
                hi_free = pae_pkg::ID_BITS'(i);
            end
        end
    end

    always_comb begin
        o_dec.id      = i_target_id;
        o_dec.evict   = 1'b0;
        o_dec.wr_en   = 1'b0;
        o_dec.wr_zero = 1'b0;
        n_mask        = r_mask;
        n_rand        = r_rand;
        case (i_command)
            pae_pkg::CMD_ALLOC: begin
                o_dec.wr_en = 1'b1;
                if (any_free) begin
                    o_dec.id = hi_free;
                    n_rand   = rand_step;
                    n_mask   = r_mask | (pae_pkg::NUM_IDS'(1) << hi_free);
                end else begin
                    o_dec.id    = rand_scr[pae_pkg::ID_BITS-1:0];
                    o_dec.evict = 1'b1;
                    n_rand      = rand_scr;
                end
            end
            pae_pkg::CMD_RELEASE: begin
                o_dec.wr_en   = 1'b1;
                o_dec.wr_zero = 1'b1;
                n_mask        = r_mask & ~(pae_pkg::NUM_IDS'(1) << i_target_id);
            end
            pae_pkg::CMD_SET_OWNER: begin
                o_dec.wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_rand <= '0;
        end else if (i_start) begin
            r_mask <= n_mask;
            r_rand <= n_rand;
        end
    end

    a_alloc_adds_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && i_command == pae_pkg::CMD_ALLOC && !o_dec.evict
        |=> $countones(r_mask) == $countones($past(r_mask)) + 1)
        else $error("free allocate did not claim exactly one identifier");

    a_evict_keeps_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && o_dec.evict |=> $stable(r_mask))
        else $error("eviction changed the in-use mask");

endmodule
